// ===== rtl/tng_pkg.sv =====
// Shared types, codes and helper functions for the two-channel tone and noise generator.
// No dependencies; every other file imports this package.
package tng_pkg;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_FF0E = 3'd0,
    SEL_FF0F = 3'd1,
    SEL_FF10 = 3'd2,
    SEL_FF11 = 3'd3,
    SEL_FF12 = 3'd4
  } reg_sel_t;

  localparam int unsigned DAC_BIT     = 7;
  localparam int unsigned FORCE_BIT   = 7;
  localparam logic [31:0] DECAY_LOAD  = 32'd131072;
  localparam logic [15:0] COUNT_RESET = 16'd1024;
  localparam logic [10:0] RELOAD_RESET = 11'd1024;
  localparam logic [7:0]  LFSR_TAPS   = 8'hB3;
  localparam logic [7:0]  LFSR_SEED   = 8'hFF;

  typedef struct packed {
    logic       command;
    logic [2:0] reg_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic       tone1_bit;
    logic       tone2_bit;
    logic       noise_bit;
    logic [6:0] volume_level;
    logic [7:0] control_byte;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic tick;
    logic dac;
    logic force_set;
  } chan_ctl_t;

  typedef struct packed {
    logic fire;
    logic square;
  } chan_sts_t;

  function automatic logic [10:0] make_reload(input logic [7:0] low, input logic [7:0] high);
    logic [9:0] f;
    logic [9:0] inv;
    f   = {high[1:0], low};
    inv = ~(f + 10'd1);
    return {1'b0, inv} + 11'd1;
  endfunction

  function automatic logic [6:0] vol_level(input logic [3:0] sel);
    logic [6:0] v;
    case (sel)
      4'd0:    v = 7'd0;
      4'd1:    v = 7'd6;
      4'd2:    v = 7'd16;
      4'd3:    v = 7'd26;
      4'd4:    v = 7'd36;
      4'd5:    v = 7'd46;
      4'd6:    v = 7'd56;
      4'd7:    v = 7'd66;
      default: v = 7'd75;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tng_chan.sv =====
// One tone channel: down-counter, decay timer, overflow flag and square bit.
// Depends on tng_pkg for the control/status structs and reset constants.
module tng_chan (
  input  logic              clk,
  input  logic              rst_n,
  input  tng_pkg::chan_ctl_t ctl,
  input  logic [10:0]       reload,
  output tng_pkg::chan_sts_t sts
);
  import tng_pkg::*;

  logic [15:0] cnt_r, cnt_nxt, cnt_dec;
  logic [31:0] decay_r, decay_nxt, decay_dec;
  logic        seen_r, seen_nxt;
  logic        sq_r, sq_nxt;
  logic        ovf;
  logic        fire;

  always_comb begin
    cnt_dec   = cnt_r - 16'd1;
    ovf       = (cnt_dec == 16'd0);
    fire      = ctl.tick && !ctl.dac && ovf && !seen_r;
    decay_dec = (fire ? DECAY_LOAD : decay_r) - 32'd1;
    cnt_nxt   = cnt_r;
    decay_nxt = decay_r;
    seen_nxt  = seen_r;
    sq_nxt    = sq_r;
    if (ctl.tick) begin
      decay_nxt = decay_dec;
      if (ctl.dac) begin
        cnt_nxt = {5'd0, reload};
        if (decay_dec == 32'd0) seen_nxt = 1'b1;
      end else begin
        cnt_nxt  = ovf ? {5'd0, reload} : cnt_dec;
        seen_nxt = ovf;
        if (fire) sq_nxt = ~sq_r;
        if (decay_dec == 32'd0) sq_nxt = 1'b1;
      end
    end else if (ctl.force_set) begin
      sq_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= COUNT_RESET;
      decay_r <= DECAY_LOAD;
      seen_r  <= 1'b0;
      sq_r    <= 1'b1;
    end else if (ctl.en) begin
      cnt_r   <= cnt_nxt;
      decay_r <= decay_nxt;
      seen_r  <= seen_nxt;
      sq_r    <= sq_nxt;
    end
  end

  assign sts.fire   = fire;
  assign sts.square = sq_nxt;

endmodule

// ===== rtl/tng_core.sv =====
// Sound registers, reload values, noise LFSR and the two tone channels.
// Depends on tng_pkg and tng_chan; result is combinational from state and the item.
module tng_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tng_pkg::in_item_t   item,
  output tng_pkg::out_item_t  result
);
  import tng_pkg::*;

  logic [7:0]  ff0e_r, ff0e_nxt;
  logic [7:0]  ff0f_r, ff0f_nxt;
  logic [7:0]  ff10_r, ff10_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  ff12_r, ff12_nxt;
  logic [10:0] reload_one_r, reload_one_nxt;
  logic [10:0] reload_two_r, reload_two_nxt;
  logic [7:0]  lfsr_r, lfsr_nxt;
  logic        lfsr_out_r, lfsr_out_nxt;
  logic        tick;
  logic        dac;
  logic        force_set;
  chan_ctl_t   ctl;
  chan_sts_t   sts_one, sts_two;

  always_comb begin
    tick           = (item.command == CMD_TICK);
    dac            = ctrl_r[DAC_BIT];
    force_set      = 1'b0;
    ff0e_nxt       = ff0e_r;
    ff0f_nxt       = ff0f_r;
    ff10_nxt       = ff10_r;
    ctrl_nxt       = ctrl_r;
    ff12_nxt       = ff12_r;
    reload_one_nxt = reload_one_r;
    reload_two_nxt = reload_two_r;
    if (!tick) begin
      case (item.reg_select)
        SEL_FF0E: begin
          ff0e_nxt       = item.write_data;
          reload_one_nxt = make_reload(item.write_data, ff12_r);
        end
        SEL_FF0F: begin
          ff0f_nxt       = item.write_data;
          reload_two_nxt = make_reload(item.write_data, ff10_r);
        end
        SEL_FF10: begin
          ff10_nxt       = item.write_data;
          reload_two_nxt = make_reload(ff0f_r, item.write_data);
        end
        SEL_FF11: begin
          ctrl_nxt  = item.write_data;
          force_set = item.write_data[FORCE_BIT];
        end
        SEL_FF12: begin
          ff12_nxt       = item.write_data;
          reload_one_nxt = make_reload(ff0e_r, item.write_data);
        end
        default: begin
        end
      endcase
    end
  end

  assign ctl.en        = en;
  assign ctl.tick      = tick;
  assign ctl.dac       = dac;
  assign ctl.force_set = force_set;

  tng_chan u_chan_one (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .reload (reload_one_r),
    .sts    (sts_one)
  );

  tng_chan u_chan_two (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .reload (reload_two_r),
    .sts    (sts_two)
  );

  always_comb begin
    lfsr_nxt     = lfsr_r;
    lfsr_out_nxt = lfsr_out_r;
    if (tick && dac) begin
      lfsr_nxt     = LFSR_SEED;
      lfsr_out_nxt = 1'b1;
    end else if (sts_two.fire) begin
      lfsr_out_nxt = lfsr_out_r ^ (^(lfsr_r & LFSR_TAPS));
      lfsr_nxt     = {lfsr_r[6:0], lfsr_out_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff0e_r       <= 8'd0;
      ff0f_r       <= 8'd0;
      ff10_r       <= 8'd0;
      ctrl_r       <= 8'd0;
      ff12_r       <= 8'd0;
      reload_one_r <= RELOAD_RESET;
      reload_two_r <= RELOAD_RESET;
      lfsr_r       <= LFSR_SEED;
      lfsr_out_r   <= 1'b1;
    end else if (en) begin
      ff0e_r       <= ff0e_nxt;
      ff0f_r       <= ff0f_nxt;
      ff10_r       <= ff10_nxt;
      ctrl_r       <= ctrl_nxt;
      ff12_r       <= ff12_nxt;
      reload_one_r <= reload_one_nxt;
      reload_two_r <= reload_two_nxt;
      lfsr_r       <= lfsr_nxt;
      lfsr_out_r   <= lfsr_out_nxt;
    end
  end

  assign result.tone1_bit    = sts_one.square;
  assign result.tone2_bit    = sts_two.square;
  assign result.noise_bit    = lfsr_out_nxt;
  assign result.volume_level = vol_level(ctrl_nxt[3:0]);
  assign result.control_byte = ctrl_nxt;

endmodule

// ===== rtl/two_channel_tone_noise_generator_top.sv =====
// Two-channel tone and noise generator: one word in is one tick or register write,
// one word out. An input register feeds tng_core, whose result lands in an output register.
// Throughput is one word per cycle while out_stall does not hold the output; an accepted
// word passes the input register, then the result register onto out_word, and waits while
// out_stall holds the word already there. All channel, LFSR and register work is
// combinational between the two registers. in_stall rises only while both registers
// hold words and the output side stalls.
module two_channel_tone_noise_generator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tng_pkg::in_item_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tng_pkg::out_item_t out_word
);
  import tng_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  logic      commit;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign commit   = in_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_word;
    end
  end

  tng_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (commit),
    .item   (in_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_item_r;

endmodule

// ===== rtl/tng_checker.sv =====
// Port-level checks for the tone and noise generator, bound to the top level.
// Depends on tng_pkg for the word structs and codes.
module tng_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tng_pkg::in_item_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input tng_pkg::out_item_t out_word
);
  import tng_pkg::*;

  logic force_wr;

  assign force_wr = in_valid && !in_stall && (in_word.command == CMD_WRITE) &&
                    (in_word.reg_select == SEL_FF11) && in_word.write_data[FORCE_BIT];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed or dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_force_set: assert property (@(posedge clk) disable iff (!rst_n)
    force_wr ##1 !out_stall |=> out_valid && out_word.tone1_bit && out_word.tone2_bit &&
      (out_word.control_byte == $past(in_word.write_data, 2)))
    else $error("control write with force bit not reflected");

  a_vol_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.control_byte[3] |-> out_word.volume_level == 7'd75)
    else $error("volume level does not match control nibble");

endmodule

bind two_channel_tone_noise_generator_top tng_checker u_tng_checker (.*);

// ===== tb/tb_two_channel_tone_noise_generator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for two_channel_tone_noise_generator_top: a queue-fed driver, a scoreboard
// monitor and a cycle model of the tone counters, decay timers and noise LFSR.
// Depends on tng_pkg for the word types and codes, and on the top-level RTL.
module tb_two_channel_tone_noise_generator_top;
  import tng_pkg::*;

  localparam logic [2:0]  SEL_SPARE_LO = 3'd5;
  localparam logic [2:0]  SEL_SPARE_HI = 3'd7;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned RANDOM_WORDS = 420;
  localparam int unsigned DECAY_RUN    = 60;
  localparam int unsigned DAC_RUN      = 40;
  localparam int unsigned LONG_HOLD    = 600;

  typedef struct packed {
    logic     drain;
    in_item_t word;
  } pend_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_word;

  pend_t     pending_words [$];
  out_item_t expected_out  [$];

  int unsigned words_in     = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned queued       = 0;
  int unsigned dac_ticks    = 0;
  int unsigned toggles_seen = 0;

  // tone/noise model state
  logic [7:0]  snd_reg [5];
  logic [10:0] reload_val [2];
  logic [15:0] down_cnt [2];
  logic [31:0] decay_cnt [2];
  logic [1:0]  ovf_seen;
  logic [1:0]  square;
  logic [7:0]  noise_sr;
  logic        noise_bit;

  two_channel_tone_noise_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [10:0] pitch_reload(input logic [7:0] lo, input logic [7:0] hi);
    logic [9:0] f;
    f = {hi[1:0], lo};
    return {1'b0, (f + 10'd1) ^ 10'h3FF} + 11'd1;
  endfunction

  function automatic logic [6:0] volume_of(input logic [3:0] sel);
    logic [6:0] v;
    if (sel >= 4'd8) begin
      v = 7'd75;
    end else begin
      case (sel)
        4'd0:    v = 7'd0;
        4'd1:    v = 7'd6;
        default: v = 7'd6 + 7'd10 * {3'd0, sel - 4'd1};
      endcase
    end
    return v;
  endfunction

  task automatic clear_sound_model();
    int i;
    for (i = 0; i < 5; i++) snd_reg[i] = 8'h00;
    for (i = 0; i < 2; i++) begin
      reload_val[i] = RELOAD_RESET;
      down_cnt[i]   = COUNT_RESET;
      decay_cnt[i]  = DECAY_LOAD;
    end
    ovf_seen  = 2'b00;
    square    = 2'b11;
    noise_sr  = LFSR_SEED;
    noise_bit = 1'b1;
  endtask

  task automatic step_noise();
    logic [7:0] t;
    t = noise_sr & LFSR_TAPS;
    t = t ^ (t >> 1);
    t = t ^ (t >> 2);
    t = t ^ (t >> 4);
    noise_bit = noise_bit ^ t[0];
    noise_sr  = {noise_sr[6:0], noise_bit};
  endtask

  task automatic tick_tone(input int ch);
    logic ovf;
    down_cnt[ch] = down_cnt[ch] - 16'd1;
    ovf = (down_cnt[ch] == 16'd0);
    if (ovf) begin
      down_cnt[ch] = {5'd0, reload_val[ch]};
      if (!ovf_seen[ch]) begin
        decay_cnt[ch] = DECAY_LOAD;
        square[ch]    = ~square[ch];
        toggles_seen++;
        if (ch == 1) step_noise();
      end
    end
    ovf_seen[ch]  = ovf;
    decay_cnt[ch] = decay_cnt[ch] - 32'd1;
    if (decay_cnt[ch] == 32'd0) square[ch] = 1'b1;
  endtask

  task automatic sound_step(input in_item_t w, output out_item_t r);
    int i;
    if (w.command == CMD_WRITE) begin
      case (w.reg_select)
        SEL_FF0E: begin
          snd_reg[0]    = w.write_data;
          reload_val[0] = pitch_reload(snd_reg[0], snd_reg[4]);
        end
        SEL_FF0F, SEL_FF10: begin
          snd_reg[w.reg_select] = w.write_data;
          reload_val[1] = pitch_reload(snd_reg[1], snd_reg[2]);
        end
        SEL_FF11: begin
          snd_reg[3] = w.write_data;
          if (w.write_data[FORCE_BIT]) square = 2'b11;
        end
        SEL_FF12: begin
          snd_reg[4]    = w.write_data;
          reload_val[0] = pitch_reload(snd_reg[0], snd_reg[4]);
        end
        default: ;
      endcase
    end else if (snd_reg[3][DAC_BIT]) begin
      dac_ticks++;
      for (i = 0; i < 2; i++) begin
        down_cnt[i]  = {5'd0, reload_val[i]};
        decay_cnt[i] = decay_cnt[i] - 32'd1;
        if (decay_cnt[i] == 32'd0) ovf_seen[i] = 1'b1;
      end
      noise_sr  = LFSR_SEED;
      noise_bit = 1'b1;
    end else begin
      tick_tone(0);
      tick_tone(1);
    end
    r.tone1_bit    = square[0];
    r.tone2_bit    = square[1];
    r.noise_bit    = noise_bit;
    r.volume_level = volume_of(snd_reg[3][3:0]);
    r.control_byte = snd_reg[3];
  endtask

  task automatic push_word(input logic cmd, input logic [2:0] sel, input logic [7:0] data,
                           input logic drain);
    pend_t p;
    p.drain           = drain;
    p.word.command    = cmd;
    p.word.reg_select = sel;
    p.word.write_data = data;
    pending_words.push_back(p);
    queued++;
  endtask

  task automatic push_ticks(input int unsigned n);
    int unsigned i;
    logic [2:0]  s;
    logic [7:0]  d;
    for (i = 0; i < n; i++) begin
      s = 3'($urandom_range(0, 7));
      d = 8'($urandom_range(0, 255));
      push_word(CMD_TICK, s, d, 1'b0);
    end
  endtask

  task automatic build_directed();
    push_ticks(1);
    push_word(CMD_WRITE, SEL_FF11, 8'h08, 1'b0);
    push_word(CMD_WRITE, SEL_FF0E, 8'hFF, 1'b0);
    push_word(CMD_WRITE, SEL_FF12, 8'hFF, 1'b0);
    push_word(CMD_WRITE, SEL_FF0E, 8'hFE, 1'b0);
    push_word(CMD_WRITE, SEL_FF0F, 8'h00, 1'b0);
    push_word(CMD_WRITE, SEL_FF10, 8'h00, 1'b0);
    push_word(CMD_WRITE, SEL_FF10, 8'hFC, 1'b0);
    push_word(CMD_WRITE, SEL_FF0F, 8'hFD, 1'b0);
    push_word(CMD_WRITE, SEL_FF10, 8'h03, 1'b0);
    push_ticks(6);
    push_word(CMD_WRITE, SEL_SPARE_LO, 8'hFF, 1'b0);
    push_word(CMD_WRITE, SEL_SPARE_HI, 8'h00, 1'b0);
    push_word(CMD_WRITE, SEL_FF11, 8'h80, 1'b0);
    push_ticks(2);
    push_word(CMD_WRITE, SEL_FF11, 8'h7F, 1'b0);
    push_ticks(1);
    push_word(CMD_WRITE, SEL_FF11, 8'h00, 1'b0);
  endtask

  // shortest reload on both channels, loaded by one DAC tick: the first underflow
  // rearms, later ones do not; then a reload of 1023 and a run of DAC ticks
  task automatic build_decay_runs();
    push_word(CMD_WRITE, SEL_FF0E, 8'hFE, 1'b1);
    push_word(CMD_WRITE, SEL_FF12, 8'h03, 1'b0);
    push_word(CMD_WRITE, SEL_FF0F, 8'hFE, 1'b0);
    push_word(CMD_WRITE, SEL_FF10, 8'h03, 1'b0);
    push_word(CMD_WRITE, SEL_FF11, 8'h81, 1'b0);
    push_ticks(1);
    push_word(CMD_WRITE, SEL_FF11, 8'h01, 1'b0);
    push_ticks(DECAY_RUN);
    push_word(CMD_WRITE, SEL_FF0E, 8'h00, 1'b1);
    push_word(CMD_WRITE, SEL_FF12, 8'h00, 1'b0);
    push_word(CMD_WRITE, SEL_FF0F, 8'h00, 1'b0);
    push_word(CMD_WRITE, SEL_FF10, 8'h00, 1'b0);
    push_ticks(40);
    push_word(CMD_WRITE, SEL_FF11, 8'h85, 1'b0);
    push_ticks(DAC_RUN);
    push_word(CMD_WRITE, SEL_FF11, 8'h03, 1'b0);
    push_ticks(20);
  endtask

  task automatic build_random();
    int unsigned start;
    int unsigned kind;
    logic [2:0]  s;
    logic [7:0]  d;
    logic        drain;
    start = queued;
    while (queued - start < RANDOM_WORDS) begin
      kind  = $urandom_range(0, 9);
      drain = ($urandom_range(0, 19) == 0);
      if (kind < 5) begin
        d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(224, 255));
        push_word(CMD_WRITE, kind[0] ? SEL_FF0E : SEL_FF0F, d, drain);
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) d[1:0] = 2'b11;
        push_word(CMD_WRITE, kind[0] ? SEL_FF12 : SEL_FF10, d, 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          d = 8'($urandom_range(0, 255));
          d[DAC_BIT] = ($urandom_range(0, 5) == 0);
          push_word(CMD_WRITE, SEL_FF11, d, 1'b0);
        end
        push_ticks($urandom_range(4, 40));
      end else if (kind < 8) begin
        s = 3'($urandom_range(0, 7));
        d = 8'($urandom_range(0, 255));
        push_word(CMD_WRITE, s, d, drain);
      end else begin
        push_ticks($urandom_range(1, 30));
      end
    end
  endtask

  // input side: accept, predict, advance the pending queue; output side: check results
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sound_step(in_word, want);
        expected_out.push_back(want);
        void'(pending_words.pop_front());
        words_in++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          $display("%0t ns: unexpected result, actual %h", $time, out_word);
          errors++;
        end else begin
          want = expected_out.pop_front();
          if (out_word !== want) begin
            $display("%0t ns: mismatch, expected %h actual %h", $time, want, out_word);
            if (out_word.tone1_bit !== want.tone1_bit)
              $display("  tone1_bit expected %b actual %b", want.tone1_bit, out_word.tone1_bit);
            if (out_word.tone2_bit !== want.tone2_bit)
              $display("  tone2_bit expected %b actual %b", want.tone2_bit, out_word.tone2_bit);
            if (out_word.noise_bit !== want.noise_bit)
              $display("  noise_bit expected %b actual %b", want.noise_bit, out_word.noise_bit);
            if (out_word.volume_level !== want.volume_level)
              $display("  volume_level expected %0d actual %0d",
                       want.volume_level, out_word.volume_level);
            if (out_word.control_byte !== want.control_byte)
              $display("  control_byte expected %h actual %h",
                       want.control_byte, out_word.control_byte);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // sender: bursts and gaps; hold the word while stalled; drain on request
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned taken_mark = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && words_in == taken_mark) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_words.size() == 0 ||
                 (pending_words[0].drain && expected_out.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      if (burst_left == 0) burst_left = $urandom_range(1, 32);
      in_valid <= 1'b1;
      in_word  <= pending_words[0].word;
      taken_mark = words_in;
      burst_left--;
      if (burst_left == 0)
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
  end

  // receiver: a randomly chosen stall pattern that changes now and again, plus one long hold
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && words_in >= 40) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_left[2];
      endcase
    end
  end

  initial begin
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: %0d idle cycles, %0d results pending", idle_cycles, expected_out.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clear_sound_model();
    build_directed();
    build_decay_runs();
    build_random();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || expected_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d words (%0d DAC ticks, %0d square toggles), %0d results checked",
             words_in, dac_ticks, toggles_seen, results_seen);
    $display("short-reload underflows, DAC ticks, spare selectors, long output hold");
    if (errors == 0 && expected_out.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
